// ===== rtl/tskt_pkg.sv =====
package tskt_pkg;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [DW-1:0] word_t;

	localparam word_t SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam word_t SMIN = {1'b1, {(DW-1){1'b0}}};
	localparam word_t ONE = word_t'(64'(1) << FB);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE     = 3'd0,
		REG_Q_POS      = 3'd1,
		REG_Q_VEL      = 3'd2,
		REG_MEAS_NOISE = 3'd3,
		REG_STEP_TIME  = 3'd4,
		REG_START_VAR  = 3'd5,
		REG_VAR_FLOOR  = 3'd6
	} cfg_idx_t;

	// unsigned register clamped into the signed range
	function automatic word_t ureg(input logic [DW-1:0] v);
		return v[DW-1] ? SMAX : word_t'(v);
	endfunction

	// saturating add
	function automatic word_t sadd(input word_t a, input word_t b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1]) return s[DW] ? SMIN : SMAX;
		return s[DW-1:0];
	endfunction

	// saturating negate
	function automatic word_t sneg(input word_t b);
		if (b == SMIN) return SMAX;
		return -b;
	endfunction

endpackage

// ===== rtl/two_state_kalman_tracker.sv =====
// Two-state constant-velocity Kalman tracker, Q16.16 fixed point.
// Input channel: measurement with valid/ready; one item per measured position.
// Output channel: est_position / est_velocity with valid/ready.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; registers
//   0 enable, 1 q_position, 2 q_velocity, 3 meas_noise, 4 step_time,
//   5 start_variance, 6 variance_floor. Writes that leave it disabled reload state.
// Sequence: disabled, out_valid rises in the cycle after the item is accepted
//   (pass-through). Enabled, predict work runs on one shared registered
//   multiplier, two restoring divides form the gains (K0 then K1), then
//   come the update products, the variance floor and the output load.
//   With a zero denominator the divides are skipped.
// Throughput: one item at a time; ready drops from accept until the result
//   has been taken and returns the cycle after. ready is also low while a
//   config write is offered; the write goes first.
// Reset: enable=0, registers take their defaults, state is x=0,
//   P=diag(start_variance).
// Stall: the result sits in output registers until out_ready; input ready
//   stays low meanwhile, nothing is lost.
module two_state_kalman_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid,
	output logic                          ready,
	input  logic signed [31:0]            measurement,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            est_position,
	output logic signed [31:0]            est_velocity,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tskt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import tskt_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_M1   = 11'b00000000010,  // dt*var_vel, dt*vel, dt*cov issued
		S_M2   = 11'b00000000100,  // collect, issue dt*a
		S_M3   = 11'b00000001000,  // wait for dt*a
		S_M4   = 11'b00000010000,  // form Pm00, den
		S_D0   = 11'b00000100000,  // K0 divide
		S_D1   = 11'b00001000000,  // K1 divide
		S_U    = 11'b00010000000,  // update products
		S_UW   = 11'b00100000000,
		S_FIN  = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	state_t state_q;

	// configuration
	logic        en_q;
	logic [31:0] qp_q, qv_q, rn_q, dt_q, sv_q, fl_q;

	// filter state
	word_t pos_q, vel_q, vp_q, cov_q, vv_q;
	word_t z_q, a_q, pm00_q, pm11_q, pm_q, den_q, k0_q, k1_q, e_q;
	word_t t0_q, t1_q;
	logic [3:0] step_q;

	// shared multiplier
	word_t m_a, m_b, m_p;
	tskt_mul u_mul (.clk(clk), .a(m_a), .b(m_b), .p_q(m_p));

	// divider
	logic  d_start, d_done;
	word_t d_num, d_quo;
	tskt_div u_div (.clk(clk), .arst_n(arst_n), .start(d_start), .num(d_num),
		.den(den_q), .done(d_done), .quo(d_quo));

	word_t dt;
	assign dt = ureg(dt_q);
	// a pending config write wins the idle cycle
	assign ready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// multiplier operand select by sequence step
	always_comb begin
		m_a = dt;
		m_b = vv_q;
		case (step_q)
			4'd0: begin m_a = dt; m_b = vv_q; end
			4'd1: begin m_a = dt; m_b = vel_q; end
			4'd2: begin m_a = dt; m_b = cov_q; end
			4'd3: begin m_a = dt; m_b = a_q; end
			4'd4: begin m_a = k0_q; m_b = e_q; end
			4'd5: begin m_a = k1_q; m_b = e_q; end
			4'd6: begin m_a = k0_q; m_b = pm00_q; end
			4'd7: begin m_a = k0_q; m_b = a_q; end
			4'd8: begin m_a = k1_q; m_b = a_q; end
			default: begin m_a = dt; m_b = vv_q; end
		endcase
	end

	assign d_start = (state_q == S_M4 && step_q == 4'd1 && den_q != '0) ||
		(state_q == S_D0 && d_done);
	assign d_num = (state_q == S_D0) ? a_q : pm00_q;

	word_t pos_n, vel_n;
	assign pos_n = sadd(pm_q, t0_q);
	assign vel_n = sadd(vel_q, t1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			en_q    <= 1'b0;
			qp_q    <= 32'd66;
			qv_q    <= 32'd66;
			rn_q    <= 32'd65536;
			dt_q    <= 32'd655;
			sv_q    <= 32'd65536;
			fl_q    <= 32'd3277;
			pos_q   <= '0;
			vel_q   <= '0;
			cov_q   <= '0;
			vp_q    <= word_t'(32'd65536);
			vv_q    <= word_t'(32'd65536);
			z_q     <= '0;
			a_q     <= '0;
			pm00_q  <= '0;
			pm11_q  <= '0;
			pm_q    <= '0;
			den_q   <= '0;
			k0_q    <= '0;
			k1_q    <= '0;
			e_q     <= '0;
			t0_q    <= '0;
			t1_q    <= '0;
			est_position <= '0;
			est_velocity <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						logic en_n;
						logic [31:0] sv_n;
						en_n = en_q;
						sv_n = sv_q;
						case (cfg_index)
							REG_ENABLE:     en_n = cfg_data[0];
							REG_Q_POS:      qp_q <= cfg_data;
							REG_Q_VEL:      qv_q <= cfg_data;
							REG_MEAS_NOISE: rn_q <= cfg_data;
							REG_STEP_TIME:  dt_q <= cfg_data;
							REG_START_VAR:  sv_n = cfg_data;
							REG_VAR_FLOOR:  fl_q <= cfg_data;
							default: ;
						endcase
						en_q <= en_n;
						sv_q <= sv_n;
						if (cfg_index <= REG_VAR_FLOOR && !en_n) begin
							pos_q <= '0;
							vel_q <= '0;
							cov_q <= '0;
							vp_q  <= ureg(sv_n);
							vv_q  <= ureg(sv_n);
						end
					end else if (valid) begin
						z_q <= measurement;
						if (!en_q) begin
							pos_q <= '0;
							vel_q <= '0;
							cov_q <= '0;
							vp_q  <= ureg(sv_q);
							vv_q  <= ureg(sv_q);
							est_position <= measurement;
							est_velocity <= '0;
							state_q <= S_OUT;
						end else begin
							step_q  <= 4'd0;
							state_q <= S_M1;
						end
					end
				end
				S_M1: begin
					// issue steps 0,1,2 on consecutive cycles
					if (step_q == 4'd0) begin
						step_q <= 4'd1;
					end else if (step_q == 4'd1) begin
						a_q <= sadd(cov_q, m_p);   // dt*var_vel
						step_q <= 4'd2;
					end else begin
						pm_q <= sadd(pos_q, m_p);  // dt*vel
						step_q <= 4'd3;
						state_q <= S_M2;
					end
				end
				S_M2: begin
					t0_q   <= sadd(vp_q, m_p);     // var_pos + dt*cov
					pm11_q <= sadd(vv_q, ureg(qv_q));
					state_q <= S_M3;
				end
				S_M3: begin
					state_q <= S_M4;
					step_q  <= 4'd0;
				end
				S_M4: begin
					if (step_q == 4'd0) begin
						pm00_q <= sadd(sadd(t0_q, m_p), ureg(qp_q));
						den_q  <= sadd(sadd(sadd(t0_q, m_p), ureg(qp_q)), ureg(rn_q));
						step_q <= 4'd1;
					end else begin
						e_q <= sadd(z_q, sneg(pm_q));
						if (den_q == '0) begin
							k0_q <= ONE;
							k1_q <= '0;
							step_q <= 4'd4;
							state_q <= S_U;
						end else begin
							state_q <= S_D0;
						end
					end
				end
				S_D0: begin
					if (d_done) begin
						k0_q <= d_quo;
						state_q <= S_D1;
					end
				end
				S_D1: begin
					if (d_done) begin
						k1_q <= d_quo;
						step_q <= 4'd4;
						state_q <= S_U;
					end
				end
				S_U: begin
					// steps 4..8 issued back to back; each registered result is collected on the next step
					if (step_q != 4'd4) begin
						case (step_q)
							4'd5: t0_q <= m_p;
							4'd6: t1_q <= m_p;
							4'd7: vp_q <= sadd(pm00_q, sneg(m_p));
							4'd8: cov_q <= sadd(a_q, sneg(m_p));
							default: ;
						endcase
					end
					if (step_q == 4'd8) state_q <= S_UW;
					step_q <= step_q + 4'd1;
				end
				S_UW: begin
					vv_q <= sadd(pm11_q, sneg(m_p));
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (vp_q < ureg(fl_q)) vp_q <= ureg(fl_q);
					if (vv_q < ureg(fl_q)) vv_q <= ureg(fl_q);
					pos_q <= pos_n;
					vel_q <= vel_n;
					est_position <= pos_n;
					est_velocity <= vel_n;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/tskt_mul.sv =====
// One fixed-point multiply per cycle, registered: truncate toward zero, saturate.
module tskt_mul (
	input  logic                 clk,
	input  tskt_pkg::word_t      a,
	input  tskt_pkg::word_t      b,
	output tskt_pkg::word_t      p_q
);
	import tskt_pkg::*;

	logic [DW-1:0]   ma, mb;
	logic [2*DW-1:0] prod;
	logic            neg;
	logic [2*DW-1:0] sh;
	word_t           res;

	always_comb begin
		ma   = a[DW-1] ? (~a + 1'b1) : a;
		mb   = b[DW-1] ? (~b + 1'b1) : b;
		neg  = a[DW-1] ^ b[DW-1];
		prod = (2*DW)'(ma) * (2*DW)'(mb);
		sh   = prod >> FB;
		if (sh[2*DW-1:DW-1] != '0) begin
			if (neg && sh == (2*DW)'({1'b1, {(DW-1){1'b0}}})) res = SMIN;
			else res = neg ? SMIN : SMAX;
		end else begin
			res = neg ? -word_t'(sh[DW-1:0]) : word_t'(sh[DW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		p_q <= res;
	end
endmodule

// ===== rtl/tskt_div.sv =====
// Restoring fixed-point divider, one quotient bit per cycle. den must be nonzero.
module tskt_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tskt_pkg::word_t num,
	input  tskt_pkg::word_t den,
	output logic            done,
	output tskt_pkg::word_t quo
);
	import tskt_pkg::*;

	localparam int QW = DW + FB;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0] x_q, q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic          neg_q, busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   r_sh, r_sub;
	logic [DW-1:0] mx, md;

	always_comb begin
		mx    = num[DW-1] ? (~num + 1'b1) : num;
		md    = den[DW-1] ? (~den + 1'b1) : den;
		r_sh  = {r_q[DW-1:0], x_q[QW-1]};
		r_sub = r_sh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(QW - 1)) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= {mx, {FB{1'b0}}};
			q_q   <= '0;
			r_q   <= '0;
			d_q   <= md;
			neg_q <= num[DW-1] ^ den[DW-1];
			cnt_q <= '0;
		end else if (busy_q) begin
			x_q   <= x_q << 1;
			cnt_q <= cnt_q + 1'b1;
			if (!r_sub[DW]) begin
				r_q <= r_sub;
				q_q <= {q_q[QW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[QW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (q_q[QW-1:DW-1] != '0) quo = neg_q ? SMIN : SMAX;
		else quo = neg_q ? -word_t'(q_q[DW-1:0]) : word_t'(q_q[DW-1:0]);
	end
endmodule
